// File: rtl/hndl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hndl_pkg
// Shared constants and types of the hashed name directory lookup core.
// ----------------------------------------------------------------------------
package hndl_pkg;

   localparam int DIR_DEPTH    = 1024;
   localparam int IDX_W        = $clog2(DIR_DEPTH);
   localparam int CNT_W        = $clog2(DIR_DEPTH + 1);

   localparam int MAX_NAME_LEN = 255;
   localparam int POS_W        = $clog2(MAX_NAME_LEN + 1);
   localparam int FIRST_WEIGHT = 3;
   localparam int WGT_W        = $clog2(MAX_NAME_LEN + FIRST_WEIGHT);

   localparam int WORD_W       = 32;
   localparam int CHAR_W       = 8;
   localparam int TOP_SHIFT    = 24;
   localparam int LOW_W        = TOP_SHIFT;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_CHAR   = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] hash;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

// File: rtl/hndl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hndl request and response channels
// Valid/ready channels carrying one request word or one lookup result word.
// ----------------------------------------------------------------------------
interface hndl_req_if;
   import hndl_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [CHAR_W-1:0] name_char;
   logic              is_last;
   logic [WORD_W-1:0] entry_hash;
   logic [WORD_W-1:0] entry_offset;
   logic [WORD_W-1:0] entry_size;

   modport source (output valid, req_type, name_char, is_last,
                   entry_hash, entry_offset, entry_size, input ready);
   modport sink   (input valid, req_type, name_char, is_last,
                   entry_hash, entry_offset, entry_size, output ready);
endinterface

interface hndl_rsp_if;
   import hndl_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [WORD_W-1:0] name_hash;
   logic [WORD_W-1:0] found_offset;
   logic [WORD_W-1:0] found_size;
   logic [IDX_W-1:0]  found_index;
   logic              name_overflow;

   modport source (output valid, found, name_hash, found_offset, found_size,
                   found_index, name_overflow, input ready);
   modport sink   (input valid, found, name_hash, found_offset, found_size,
                   found_index, name_overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/hndl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hndl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hndl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/hashed_name_directory_lookup_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_name_directory_lookup_core
// Name hashing, last-hit cache and binary search over a sorted directory.
// ----------------------------------------------------------------------------
// Clear, append and non-final characters are taken one word per cycle.
// A final character starts a lookup: S_MUL forms the hash, a too-long name
// goes straight to S_DONE, S_CCHK checks the cached slot, and a search runs
// S_PROBE and S_PCHK per probe. No request is taken while a lookup runs.
// Reset (synchronous): empty directory, cache and name state cleared; the
// table memory itself is not cleared.
module hashed_name_directory_lookup_core (
   input wire logic   clock,
   input wire logic   reset,
   hndl_req_if.sink   req_ch,
   hndl_rsp_if.source rsp_ch
);
   import hndl_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_CCHK  = 6'b000100,
      S_PROBE = 6'b001000,
      S_PCHK  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              cache_valid_ff, cache_valid_in;
   logic [IDX_W-1:0]  cache_slot_ff, cache_slot_in;
   logic [LOW_W-1:0]  odd_ff, odd_in;
   logic [LOW_W-1:0]  even_ff, even_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CHAR_W-1:0] top_ff, top_in;
   logic              too_long_ff, too_long_in;

   logic [WORD_W-1:0] hash_ff, hash_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [WORD_W-1:0] off_ff, off_in;
   logic [WORD_W-1:0] size_ff, size_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [WORD_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [WORD_W-1:0] rsp_off_ff, rsp_off_in;
   logic [WORD_W-1:0] rsp_size_ff, rsp_size_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic [WGT_W-1:0]  weight;
   logic [LOW_W-1:0]  wchar;
   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid;
   logic [2*LOW_W-1:0] product;
   logic              wr_en;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         wr_entry;
   entry_type         rd_entry;
   logic [ENTRY_W-1:0] rd_data;

   hndl_ram #(.WIDTH(ENTRY_W), .DEPTH(DIR_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign wr_entry = '{hash: req_ch.entry_hash, offset: req_ch.entry_offset,
                       size: req_ch.entry_size};

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_en        = accept && (req_ch.req_type == REQ_APPEND) &&
                         (count_ff < CNT_W'(DIR_DEPTH));

   assign weight  = WGT_W'(pos_ff) + WGT_W'(FIRST_WEIGHT);
   assign wchar   = LOW_W'(weight * req_ch.name_char);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];
   assign product = odd_ff * even_ff;
   assign rd_addr = (state_ff == S_MUL) ? cache_slot_ff : mid[IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cache_valid_in = cache_valid_ff;
      cache_slot_in  = cache_slot_ff;
      odd_in         = odd_ff;
      even_in        = even_ff;
      pos_in         = pos_ff;
      top_in         = top_ff;
      too_long_in    = too_long_ff;
      hash_in        = hash_ff;
      ovf_in         = ovf_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      off_in         = off_ff;
      size_in        = size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_hash_in    = rsp_hash_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_ch.req_type)
                  REQ_CLEAR: begin
                     count_in       = '0;
                     cache_valid_in = 1'b0;
                  end
                  REQ_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_CHAR: begin
                     if (pos_ff >= POS_W'(MAX_NAME_LEN)) begin
                        too_long_in = 1'b1;
                     end else begin
                        if (weight[0]) begin
                           odd_in = odd_ff + wchar;
                        end else begin
                           even_in = even_ff + wchar;
                        end
                        if (pos_ff < POS_W'(2)) begin
                           top_in = top_ff ^ req_ch.name_char;
                        end
                        pos_in = pos_ff + POS_W'(1);
                     end
                     if (req_ch.is_last) begin
                        state_in = S_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            hash_in     = {top_ff, product[LOW_W-1:0]};
            ovf_in      = too_long_ff;
            hit_in      = 1'b0;
            slot_in     = '0;
            off_in      = '0;
            size_in     = '0;
            lo_in       = '0;
            hi_in       = count_ff;
            odd_in      = '0;
            even_in     = '0;
            pos_in      = '0;
            top_in      = '0;
            too_long_in = 1'b0;
            priority if (too_long_ff) begin
               state_in = S_DONE;
            end else if (cache_valid_ff && ({1'b0, cache_slot_ff} < count_ff)) begin
               state_in = S_CCHK;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_CCHK: begin
            if (rd_entry.hash == hash_ff) begin
               hit_in   = 1'b1;
               slot_in  = cache_slot_ff;
               off_in   = rd_entry.offset;
               size_in  = rd_entry.size;
               state_in = S_DONE;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid[IDX_W-1:0];
               state_in = S_PCHK;
            end else begin
               cache_valid_in = 1'b0;
               state_in       = S_DONE;
            end
         end
         S_PCHK: begin
            priority if (hash_ff < rd_entry.hash) begin
               hi_in    = {1'b0, mid_ff};
               state_in = S_PROBE;
            end else if (hash_ff > rd_entry.hash) begin
               lo_in    = {1'b0, mid_ff} + CNT_W'(1);
               state_in = S_PROBE;
            end else begin
               hit_in         = 1'b1;
               slot_in        = mid_ff;
               off_in         = rd_entry.offset;
               size_in        = rd_entry.size;
               cache_valid_in = 1'b1;
               cache_slot_in  = mid_ff;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_hash_in  = hash_ff;
               rsp_off_in   = off_ff;
               rsp_size_in  = size_ff;
               rsp_index_in = slot_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         cache_valid_ff <= 1'b0;
         cache_slot_ff  <= '0;
         odd_ff         <= '0;
         even_ff        <= '0;
         pos_ff         <= '0;
         top_ff         <= '0;
         too_long_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         cache_valid_ff <= cache_valid_in;
         cache_slot_ff  <= cache_slot_in;
         odd_ff         <= odd_in;
         even_ff        <= even_in;
         pos_ff         <= pos_in;
         top_ff         <= top_in;
         too_long_ff    <= too_long_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      ovf_ff       <= ovf_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      off_ff       <= off_in;
      size_ff      <= size_in;
      rsp_found_ff <= rsp_found_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.name_hash     = rsp_hash_ff;
   assign rsp_ch.found_offset  = rsp_off_ff;
   assign rsp_ch.found_size    = rsp_size_ff;
   assign rsp_ch.found_index   = rsp_index_ff;
   assign rsp_ch.name_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Hashed name directory lookup testbench
// Loads directories of named entries, feeds file names one character per
// word and scores each lookup result against a behavioral copy of the core:
// hashing, last-hit cache, binary search, full directory and long names.
// ----------------------------------------------------------------------------
module testbench;
   import hndl_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         LONG_LEN     = MAX_NAME_LEN + 1;
   localparam int         DRAIN_LIMIT  = 20000;
   localparam int         SETTLE_TICKS = 40;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic [WORD_W-1:0] hash;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
   } req_word_t;

   typedef struct packed {
      logic [WORD_W-1:0] odd_sum;
      logic [WORD_W-1:0] even_sum;
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] top;
      logic              overflow;
   } name_acc_t;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] name_hash;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
      logic [IDX_W-1:0]  index;
      logic              overflow;
   } lookup_result_t;

   typedef struct packed {
      logic [15:0][CHAR_W-1:0] chars;
      logic [4:0]              len;
   } short_name_t;

   logic clock;
   logic reset;

   hndl_req_if req_ch();
   hndl_rsp_if rsp_ch();

   hashed_name_directory_lookup_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // behavioral copy of the core
   entry_type      dir_table [DIR_DEPTH];
   int             dir_count = 0;
   logic           cache_valid = 1'b0;
   int             cache_slot = 0;
   name_acc_t      name_acc = '0;
   lookup_result_t pending_results [$];

   entry_type      dir_image [DIR_DEPTH];
   short_name_t    name_lib [$];

   int error_count = 0;
   int words_sent = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int hold_off = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 1000000);
      $display("FAIL");
      $finish;
   end

   function automatic name_acc_t fold_char(name_acc_t a, logic [CHAR_W-1:0] ch);
      logic [WORD_W-1:0] w;
      if (a.pos >= MAX_NAME_LEN) begin
         a.overflow = 1'b1;
      end else begin
         w = WORD_W'(a.pos);
         w = w + FIRST_WEIGHT;
         if (w[0]) begin
            a.odd_sum = a.odd_sum + w * ch;
         end else begin
            a.even_sum = a.even_sum + w * ch;
         end
         if (a.pos < 2) begin
            a.top = a.top ^ ch;
         end
         a.pos = a.pos + 1'b1;
      end
      return a;
   endfunction

   function automatic logic [WORD_W-1:0] name_hash_value(name_acc_t a);
      logic [WORD_W-1:0] p;
      p = a.odd_sum * a.even_sum;
      return {a.top, p[LOW_W-1:0]};
   endfunction

   function automatic logic [WORD_W-1:0] hash_of_name(short_name_t n);
      name_acc_t acc;
      acc = '0;
      for (int i = 0; i < n.len; i++) acc = fold_char(acc, n.chars[i]);
      return name_hash_value(acc);
   endfunction

   function automatic void apply_request(req_word_t w);
      lookup_result_t r;
      logic           hit;
      int             lo, hi, mid, slot;
      case (w.kind)
         REQ_CLEAR: begin
            dir_count = 0;
            cache_valid = 1'b0;
         end
         REQ_APPEND: begin
            if (dir_count < DIR_DEPTH) begin
               dir_table[dir_count].hash = w.hash;
               dir_table[dir_count].offset = w.offset;
               dir_table[dir_count].size = w.size;
               dir_count++;
            end
         end
         REQ_CHAR: begin
            name_acc = fold_char(name_acc, w.ch);
            if (w.last) begin
               r = '0;
               r.name_hash = name_hash_value(name_acc);
               r.overflow = name_acc.overflow;
               hit = 1'b0;
               slot = 0;
               if (!name_acc.overflow) begin
                  if (cache_valid && cache_slot < dir_count &&
                      dir_table[cache_slot].hash == r.name_hash) begin
                     hit = 1'b1;
                     slot = cache_slot;
                  end else begin
                     lo = 0;
                     hi = dir_count;
                     while (lo < hi && !hit) begin
                        mid = (lo + hi) / 2;
                        if (r.name_hash < dir_table[mid].hash) begin
                           hi = mid;
                        end else if (r.name_hash > dir_table[mid].hash) begin
                           lo = mid + 1;
                        end else begin
                           hit = 1'b1;
                           slot = mid;
                        end
                     end
                     cache_valid = hit;
                     if (hit) begin
                        cache_slot = slot;
                     end
                  end
               end
               if (hit) begin
                  r.found = 1'b1;
                  r.offset = dir_table[slot].offset;
                  r.size = dir_table[slot].size;
                  r.index = IDX_W'(slot);
               end
               pending_results.push_back(r);
               name_acc = '0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s: got %0h, expected %0h", field, got, want));
      end
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      lookup_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_error("result word with no lookup pending");
         end else begin
            want = pending_results.pop_front();
            check_field("found", WORD_W'(rsp_ch.found), WORD_W'(want.found));
            check_field("name_hash", rsp_ch.name_hash, want.name_hash);
            check_field("found_offset", rsp_ch.found_offset, want.offset);
            check_field("found_size", rsp_ch.found_size, want.size);
            check_field("found_index", WORD_W'(rsp_ch.found_index), WORD_W'(want.index));
            check_field("name_overflow", WORD_W'(rsp_ch.name_overflow),
                        WORD_W'(want.overflow));
         end
      end
   end

   function automatic req_word_t junk_word(logic [1:0] kind);
      req_word_t w;
      w.kind = kind;
      w.ch = 8'($urandom);
      w.last = 1'($urandom);
      w.hash = $urandom;
      w.offset = $urandom;
      w.size = $urandom;
      return w;
   endfunction

   function automatic short_name_t random_name(int max_len);
      short_name_t n;
      n = '0;
      n.len = 5'($urandom_range(max_len, 1));
      for (int i = 0; i < n.len; i++) begin
         n.chars[i] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(126, 32));
      end
      return n;
   endfunction

   // valid stays high after acceptance; a drain, or an idle turn in the next call, lowers it
   task automatic send_word(req_word_t w);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= w.kind;
      req_ch.name_char <= w.ch;
      req_ch.is_last <= w.last;
      req_ch.entry_hash <= w.hash;
      req_ch.entry_offset <= w.offset;
      req_ch.entry_size <= w.size;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_request(w);
      if (w.kind != REQ_UNUSED) begin
         words_sent++;
      end
   endtask

   task automatic send_append(logic [WORD_W-1:0] h, logic [WORD_W-1:0] o, logic [WORD_W-1:0] s);
      req_word_t w;
      w = junk_word(REQ_APPEND);
      w.hash = h;
      w.offset = o;
      w.size = s;
      send_word(w);
   endtask

   task automatic send_name(short_name_t n);
      req_word_t w;
      for (int i = 0; i < n.len; i++) begin
         w = junk_word(REQ_CHAR);
         w.ch = n.chars[i];
         w.last = (i == n.len - 1);
         send_word(w);
      end
   endtask

   task automatic drain_results();
      int guard;
      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // n_names of the n_total entries carry hashes of fresh names kept in name_lib; sorted orders all by hash
   task automatic load_directory(int n_names, int n_total, bit sorted);
      entry_type e;
      int        j;
      name_lib.delete();
      for (int i = 0; i < n_total; i++) begin
         dir_image[i].hash = $urandom;
         dir_image[i].offset = $urandom;
         dir_image[i].size = $urandom;
         if (i < n_names) begin
            name_lib.push_back(random_name(12));
            dir_image[i].hash = hash_of_name(name_lib[i]);
         end
      end
      if (sorted) begin
         for (int i = 1; i < n_total; i++) begin
            e = dir_image[i];
            j = i;
            while (j > 0 && dir_image[j-1].hash > e.hash) begin
               dir_image[j] = dir_image[j-1];
               j--;
            end
            dir_image[j] = e;
         end
      end
      for (int i = 0; i < n_total; i++) begin
         send_append(dir_image[i].hash, dir_image[i].offset, dir_image[i].size);
      end
   endtask

   task automatic test_directed();
      short_name_t ab, one, odd;
      ab = '0;
      ab.len = 2;
      ab.chars[0] = "A";
      ab.chars[1] = "B";
      one = '0;
      one.len = 1;
      one.chars[0] = "A";
      odd = '0;
      odd.len = 3;
      odd.chars[0] = 8'h00;
      odd.chars[1] = 8'hFF;
      odd.chars[2] = 8'h01;
      send_name(one);
      send_word(junk_word(REQ_CLEAR));
      send_append(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_append(hash_of_name(ab), 32'hFFFF_FFFF, 32'h0000_0000);
      send_append(32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321);
      send_name(ab);
      send_name(ab);
      send_name(odd);
      send_word(junk_word(REQ_UNUSED));
      one.chars[0] = 8'hFF;
      send_name(one);
      send_word(junk_word(REQ_CLEAR));
      send_name(ab);
      drain_results();
   endtask

   task automatic test_random_traffic(int budget);
      int          first_word, n_names, pick;
      short_name_t recent;
      req_word_t   w;
      first_word = words_sent;
      while (words_sent - first_word < budget) begin
         send_word(junk_word(REQ_CLEAR));
         n_names = $urandom_range(6, 1);
         load_directory(n_names, n_names + $urandom_range(8), $urandom_range(99) < 85);
         recent = name_lib[0];
         repeat ($urandom_range(6, 2)) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               recent = name_lib[$urandom_range(name_lib.size() - 1)];
               send_name(recent);
            end else if (pick < 65) begin
               send_name(recent);
            end else if (pick < 85) begin
               recent = random_name(16);
               send_name(recent);
            end else if (pick < 90) begin
               send_word(junk_word(REQ_UNUSED));
            end else if (pick < 95) begin
               send_word(junk_word(REQ_APPEND));
            end else begin
               // stray character that prefixes the next name
               w = junk_word(REQ_CHAR);
               w.last = 1'b0;
               send_word(w);
               send_name(recent);
            end
         end
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      send_word(junk_word(REQ_CLEAR));
      load_directory(4, 8, 1'b1);
      hold_off = 300;
      repeat (5) send_name(name_lib[$urandom_range(name_lib.size() - 1)]);
      drain_results();
   endtask

   // name one character past the length limit; its clipped hash is listed
   task automatic test_long_names();
      logic [CHAR_W-1:0] text [LONG_LEN];
      name_acc_t         acc;
      req_word_t         w;
      acc = '0;
      for (int i = 0; i < LONG_LEN; i++) begin
         text[i] = 8'($urandom);
         if (i < MAX_NAME_LEN) begin
            acc = fold_char(acc, text[i]);
         end
      end
      send_word(junk_word(REQ_CLEAR));
      send_append(name_hash_value(acc), $urandom, $urandom);
      for (int i = 0; i < LONG_LEN; i++) begin
         w = junk_word(REQ_CHAR);
         w.ch = text[i];
         w.last = (i == LONG_LEN - 1);
         send_word(w);
      end
      drain_results();
   endtask

   task automatic test_full_directory();
      short_name_t late;
      send_word(junk_word(REQ_CLEAR));
      load_directory(3, DIR_DEPTH, 1'b1);
      late = random_name(12);
      repeat (3) send_append(hash_of_name(late), $urandom, $urandom);
      send_name(late);
      foreach (name_lib[i]) begin
         send_name(name_lib[i]);
         if ($urandom_range(2) == 0) begin
            send_name(name_lib[i]);
         end
      end
      send_word(junk_word(REQ_CLEAR));
      send_name(name_lib[0]);
      drain_results();
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_CLEAR;
      req_ch.name_char <= '0;
      req_ch.is_last <= 1'b0;
      req_ch.entry_hash <= '0;
      req_ch.entry_offset <= '0;
      req_ch.entry_size <= '0;
      rsp_ch.ready <= 1'b0;
      src_idle_pct = 22;
      sink_idle_pct = 54;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(20);
      test_backpressure();
      src_idle_pct = 54;
      sink_idle_pct = 22;
      test_random_traffic(20);
      test_long_names();
      src_idle_pct = 0;
      sink_idle_pct = 0;
      test_random_traffic(20);
      test_full_directory();
      drain_results();
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d lookup results never arrived", pending_results.size()));
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
